@@ rtl/core/cvt_pkg.sv @@
`default_nettype none

package cvt_pkg;

  localparam logic [2:0] MODE_OPEN    = 3'd0;
  localparam logic [2:0] MODE_WAIT    = 3'd1;
  localparam logic [2:0] MODE_SIGNAL  = 3'd2;
  localparam logic [2:0] MODE_BCAST   = 3'd3;
  localparam logic [2:0] MODE_DESTROY = 3'd4;

  localparam logic [4:0] MAX_RES   = 5'd16;
  localparam logic [7:0] USERS_MAX = 8'd255;
  localparam logic [31:0] KEY_RESET = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [2:0]         mode;
    logic signed [31:0] key;
    logic [3:0]         cond_index;
    logic [3:0]         waiting_task;
  } cvt_in_t;

  typedef struct packed {
    logic [3:0] slot_index;
    logic       open_failed;
    logic [3:0] released_task;
    logic       release_valid;
    logic       last;
    logic       bad_slot;
  } cvt_out_t;

endpackage

`default_nettype wire

@@ rtl/core/cvt_if.sv @@
`default_nettype none

interface cvt_in_if import cvt_pkg::*; ();
  logic    valid;
  logic    ready;
  cvt_in_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface cvt_out_if import cvt_pkg::*; ();
  logic     valid;
  logic     ready;
  cvt_out_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/core/condition_variable_table_core.sv @@
// Condition-variable table with a fixed set of slots, each holding a key, a
// saturating user count and a FIFO of waiting task ids.
// in_ch (sink): one beat is one request: open by key, wait, signal,
// broadcast or destroy. out_ch (source): result beats, last marks the final
// beat of a request; unused modes give no beat.
// Timing: a request is taken in the idle state and decoded in the next
// cycle from the queue memory's registered read. Open, wait, bad-slot and
// empty-queue requests answer from that decode step. Each release is a
// step of its own through the next-waiter memory: signal releases one
// waiter, broadcast and destroy step once per waiter (at most 16 reported;
// destroy walks on silently through further waiters).
// The result sits in an output register; a stalled receiver holds each
// reported step until the register drains, and a new request is taken
// while the last result still waits.
// Reset (synchronous, rst_n low) frees all slots and empties all queues at
// once; queue pointers are left unwritten until used.
`default_nettype none

module condition_variable_table_core import cvt_pkg::*; #(
  parameter int COND_SLOTS = 16,
  parameter int TASK_SLOTS = 16
) (
  input  wire        clk,
  input  wire        rst_n,
  cvt_in_if.sink     in_ch,
  cvt_out_if.source  out_ch
);

  localparam int SW = (COND_SLOTS > 1) ? $clog2(COND_SLOTS) : 1;
  localparam int TW = $clog2(TASK_SLOTS);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_POP  = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  cvt_in_t  req_r;
  logic     out_valid_r, out_valid_nxt;
  cvt_out_t out_data_r, out_data_nxt;

  logic [31:0] key_r   [COND_SLOTS];
  logic [7:0]  users_r [COND_SLOTS];
  logic [COND_SLOTS-1:0] nonempty_r;
  logic [TASK_SLOTS-1:0] queued_r;

  logic [2*TW-1:0] qmem [COND_SLOTS];
  logic [2*TW-1:0] q_rd_r;
  logic [TW-1:0]   nmem [TASK_SLOTS];
  logic [TW-1:0]   n_rd_r;

  logic [TW-1:0] head_r, head_nxt;
  logic [TW-1:0] tail_r, tail_nxt;
  logic [4:0]    cnt_r, cnt_nxt;

  logic            q_re, q_we;
  logic [SW-1:0]   q_raddr;
  logic [2*TW-1:0] q_wdata;
  logic            n_re, n_we;
  logic [TW-1:0]   n_raddr, n_waddr, n_wdata;

  logic          users_we, key_we;
  logic [7:0]    users_wdata;
  logic          ne_set, ne_clr;
  logic          qd_set, qd_clr;
  logic [TW-1:0] qd_idx;

  logic [SW+3:0] in_ci_ext, ci_ext;
  logic [SW-1:0] ci_idx;
  logic [TW+3:0] wt_ext;
  logic [TW-1:0] wt_idx;
  logic          ci_ok, wt_ok;
  logic          can_emit;
  logic          in_acc;

  logic          m_found, f_found;
  logic [SW-1:0] m_idx, f_idx, sel_idx;
  logic [SW+3:0] sel_ext;
  logic [TW+3:0] rel_ext;
  logic          empty_after, report, stop;
  logic [TW-1:0] q_head, q_tail;

  assign in_ch.ready  = (state_r == S_IDLE);
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;
  assign can_emit     = !out_valid_r || out_ch.ready;

  assign in_ci_ext = {{SW{1'b0}}, in_ch.data.cond_index};
  assign ci_ext    = {{SW{1'b0}}, req_r.cond_index};
  assign ci_idx    = ci_ext[SW-1:0];
  assign wt_ext    = {{TW{1'b0}}, req_r.waiting_task};
  assign wt_idx    = wt_ext[TW-1:0];
  assign ci_ok     = ({3'b000, req_r.cond_index} < 7'(COND_SLOTS));
  assign wt_ok     = ({3'b000, req_r.waiting_task} < 7'(TASK_SLOTS));

  assign q_head = q_rd_r[2*TW-1:TW];
  assign q_tail = q_rd_r[TW-1:0];

  assign empty_after = (head_r == tail_r);
  assign report      = (cnt_r < MAX_RES);
  assign stop        = empty_after || (req_r.mode == MODE_SIGNAL) ||
                       ((req_r.mode == MODE_BCAST) && (cnt_r == MAX_RES - 5'd1));
  assign rel_ext     = {4'b0000, head_r};

  // match and first-free search for open
  always_comb begin
    m_found = 1'b0;
    f_found = 1'b0;
    m_idx   = '0;
    f_idx   = '0;
    for (int i = COND_SLOTS - 1; i >= 0; i--) begin
      if ((key_r[i] == req_r.key) && (users_r[i] != 8'd0)) begin
        m_found = 1'b1;
        m_idx   = SW'(i);
      end
      if (users_r[i] == 8'd0) begin
        f_found = 1'b1;
        f_idx   = SW'(i);
      end
    end
  end

  assign sel_idx = m_found ? m_idx : f_idx;
  assign sel_ext = {4'b0000, sel_idx};

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_data_nxt  = out_data_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    cnt_nxt       = cnt_r;
    q_re          = 1'b0;
    q_raddr       = in_ci_ext[SW-1:0];
    q_we          = 1'b0;
    q_wdata       = '0;
    n_re          = 1'b0;
    n_raddr       = '0;
    n_we          = 1'b0;
    n_waddr       = '0;
    n_wdata       = '0;
    users_we      = 1'b0;
    users_wdata   = 8'd0;
    key_we        = 1'b0;
    ne_set        = 1'b0;
    ne_clr        = 1'b0;
    qd_set        = 1'b0;
    qd_clr        = 1'b0;
    qd_idx        = wt_idx;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          q_re      = 1'b1;
          state_nxt = S_EXEC;
        end
      end

      S_EXEC: begin
        out_data_nxt.slot_index    = req_r.cond_index;
        out_data_nxt.open_failed   = 1'b0;
        out_data_nxt.released_task = 4'd0;
        out_data_nxt.release_valid = 1'b0;
        out_data_nxt.last          = 1'b1;
        out_data_nxt.bad_slot      = 1'b0;
        priority if (req_r.mode > MODE_DESTROY) begin
          out_data_nxt = out_data_r;
          state_nxt    = S_IDLE;
        end else if (req_r.mode == MODE_OPEN) begin
          if (can_emit) begin
            out_valid_nxt = 1'b1;
            state_nxt     = S_IDLE;
            if (m_found || f_found) begin
              out_data_nxt.slot_index = sel_ext[3:0];
              users_we    = 1'b1;
              key_we      = !m_found;
              users_wdata = !m_found ? 8'd1 :
                            (users_r[m_idx] < USERS_MAX) ? users_r[m_idx] + 8'd1 :
                            users_r[m_idx];
            end else begin
              out_data_nxt.slot_index  = 4'd0;
              out_data_nxt.open_failed = 1'b1;
            end
          end else begin
            out_data_nxt = out_data_r;
          end
        end else if (!ci_ok || (users_r[ci_idx] == 8'd0)) begin
          if (can_emit) begin
            out_valid_nxt          = 1'b1;
            out_data_nxt.bad_slot  = 1'b1;
            state_nxt              = S_IDLE;
          end else begin
            out_data_nxt = out_data_r;
          end
        end else if (req_r.mode == MODE_WAIT) begin
          if (can_emit) begin
            out_valid_nxt = 1'b1;
            state_nxt     = S_IDLE;
            if (wt_ok && !queued_r[wt_idx]) begin
              q_we   = 1'b1;
              ne_set = 1'b1;
              qd_set = 1'b1;
              if (nonempty_r[ci_idx]) begin
                n_we    = 1'b1;
                n_waddr = q_tail;
                n_wdata = wt_idx;
                q_wdata = {q_head, wt_idx};
              end else begin
                q_wdata = {wt_idx, wt_idx};
              end
            end
          end else begin
            out_data_nxt = out_data_r;
          end
        end else if (!nonempty_r[ci_idx]) begin
          if (can_emit) begin
            out_valid_nxt = 1'b1;
            state_nxt     = S_IDLE;
            users_we      = (req_r.mode == MODE_DESTROY);
          end else begin
            out_data_nxt = out_data_r;
          end
        end else begin
          out_data_nxt = out_data_r;
          users_we     = (req_r.mode == MODE_DESTROY);
          head_nxt     = q_head;
          tail_nxt     = q_tail;
          cnt_nxt      = 5'd0;
          n_re         = 1'b1;
          n_raddr      = q_head;
          state_nxt    = S_POP;
        end
      end

      S_POP: begin
        if (!report || can_emit) begin
          qd_clr = 1'b1;
          qd_idx = head_r;
          if (empty_after) begin
            ne_clr = 1'b1;
          end else begin
            q_we     = 1'b1;
            q_wdata  = {n_rd_r, tail_r};
            head_nxt = n_rd_r;
            n_re     = 1'b1;
            n_raddr  = n_rd_r;
          end
          if (report) begin
            out_valid_nxt              = 1'b1;
            out_data_nxt.slot_index    = req_r.cond_index;
            out_data_nxt.open_failed   = 1'b0;
            out_data_nxt.released_task = rel_ext[3:0];
            out_data_nxt.release_valid = 1'b1;
            out_data_nxt.last          = stop || (cnt_r == MAX_RES - 5'd1);
            out_data_nxt.bad_slot      = 1'b0;
            cnt_nxt                    = cnt_r + 5'd1;
          end
          if (stop) begin
            state_nxt = S_IDLE;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (q_we) begin
      qmem[ci_idx] <= q_wdata;
    end
    if (q_re) begin
      q_rd_r <= qmem[q_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (n_we) begin
      nmem[n_waddr] <= n_wdata;
    end
    if (n_re) begin
      n_rd_r <= nmem[n_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      nonempty_r  <= '0;
      queued_r    <= '0;
      for (int i = 0; i < COND_SLOTS; i++) begin
        users_r[i] <= 8'd0;
        key_r[i]   <= KEY_RESET;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (users_we) begin
        users_r[(req_r.mode == MODE_OPEN) ? sel_idx : ci_idx] <= users_wdata;
      end
      if (key_we) begin
        key_r[sel_idx] <= req_r.key;
      end
      if (ne_set) begin
        nonempty_r[ci_idx] <= 1'b1;
      end
      if (ne_clr) begin
        nonempty_r[ci_idx] <= 1'b0;
      end
      if (qd_set) begin
        queued_r[qd_idx] <= 1'b1;
      end
      if (qd_clr) begin
        queued_r[qd_idx] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      req_r <= in_ch.data;
    end
    out_data_r <= out_data_nxt;
    head_r     <= head_nxt;
    tail_r     <= tail_nxt;
    cnt_r      <= cnt_nxt;
  end

endmodule

`default_nettype wire
